>>> rtl/core/dlsbs_pkg.sv
// Package for the display line scroll/blink sequencer core.
// Holds the op and effect codes, per-line state type and timing constants.
// No dependencies.
package dlsbs_pkg;

   localparam int TEXT_COLUMNS          = 20;
   localparam int DEFAULT_EFFECT_PERIOD = 100;
   localparam int DEFAULT_BLINK_PERIOD  = 250;
   localparam int BOUNCE_PERIOD         = 100;
   localparam int SCROLL_PERIOD         = 50;

   localparam int NUM_LINES  = 2;
   localparam int OFFSET_W   = 10;
   localparam int LEN_W      = 8;
   localparam int PERIOD_W   = 16;
   localparam int TIME_W     = 32;
   localparam int PHASE_W    = 3;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 48;

   // bounce phases where the left-going and right-going sweeps run
   localparam logic [PHASE_W-1:0] BOUNCE_SWEEP_LEFT  = 3'd0;
   localparam logic [PHASE_W-1:0] BOUNCE_SWEEP_RIGHT = 3'd4;

   localparam logic signed [OFFSET_W:0] COLS_S = (OFFSET_W+1)'(TEXT_COLUMNS);

   typedef enum logic [2:0] {
      OP_LOAD        = 3'd0,
      OP_EFFECT_TICK = 3'd1,
      OP_BLINK_START = 3'd2,
      OP_BLINK_STOP  = 3'd3,
      OP_BLINK_TICK  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      FX_OFF    = 2'd0,
      FX_BOUNCE = 2'd1,
      FX_LEFT   = 2'd2,
      FX_RIGHT  = 2'd3
   } effect_type;

   typedef struct packed {
      effect_type                 effect_mode;
      logic                       effect_running;
      logic [PHASE_W-1:0]         bounce_phase;
      logic signed [OFFSET_W-1:0] offset;
      logic [LEN_W-1:0]           text_length;
      logic [PERIOD_W-1:0]        tick_period;
      logic                       blinking;
      logic                       blink_phase;
      logic [PERIOD_W-1:0]        blink_duration;
      logic [TIME_W-1:0]          blink_start_time;
      logic [PERIOD_W-1:0]        blink_tick_period;
   } line_state_type;

   localparam line_state_type LINE_RESET = '{
      effect_mode:       FX_OFF,
      effect_running:    1'b0,
      bounce_phase:      '0,
      offset:            '0,
      text_length:       '0,
      tick_period:       PERIOD_W'(DEFAULT_EFFECT_PERIOD),
      blinking:          1'b0,
      blink_phase:       1'b0,
      blink_duration:    '0,
      blink_start_time:  '0,
      blink_tick_period: PERIOD_W'(DEFAULT_BLINK_PERIOD)
   };

endpackage

>>> rtl/core/display_line_scroll_blink_sequencer_core.sv
// Top level of the display line scroll/blink sequencer.
// Uses dlsbs_pkg for codes, the per-line state type and constants.
//
// Path: an item taken into the input register moves on into the result
//   register once that register is free or is being read out.
// Throughput: one item per cycle unless rsp_tready stalls the output; the
//   per-line update is one short combinational step between the input
//   register and the state/result registers.
// Reset: synchronous, active high; both lines return to their default state
//   (effect off, default tick periods) at once, no clearing pass; no item is
//   accepted while reset is high.
module display_line_scroll_blink_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // effect[1:0], msg_len[9:2], blink_interval[25:10], blink_limit[41:26],
   // now_ms[73:42], zero fill above
   input  logic [dlsbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[2:0], line[3]
   input  logic [dlsbs_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // char_offset[8:0], show_blink_text[9], effect_active[10],
   // effect_period[26:11], blink_active[27], blink_period_out[43:28], zero fill above
   output logic [dlsbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // out_line
   output logic                                 rsp_tuser
);
   import dlsbs_pkg::*;

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic                    s1_valid_ff;
   logic [2:0]              s1_op_ff;
   logic                    s1_line_ff;
   logic [1:0]              s1_effect_ff;
   logic [LEN_W-1:0]        s1_len_ff;
   logic [PERIOD_W-1:0]     s1_interval_ff;
   logic [PERIOD_W-1:0]     s1_limit_ff;
   logic [TIME_W-1:0]       s1_now_ff;

   // stage-1 item moves into the result register when that register is free or being read out
   logic advance;
   logic req_fire;

   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_fire) begin
         s1_op_ff       <= req_tuser[2:0];
         s1_line_ff     <= req_tuser[3];
         s1_effect_ff   <= req_tdata[1:0];
         s1_len_ff      <= req_tdata[9:2];
         s1_interval_ff <= req_tdata[25:10];
         s1_limit_ff    <= req_tdata[41:26];
         s1_now_ff      <= req_tdata[73:42];
      end
   end

   // ---------------------------------------------------------------
   // Per-line state and update
   // ---------------------------------------------------------------
   line_state_type state_ff [NUM_LINES];
   line_state_type cur;
   line_state_type state_in;

   logic signed [OFFSET_W:0] off_ext;
   logic signed [OFFSET_W:0] off_dec;
   logic signed [OFFSET_W:0] off_inc;
   logic signed [OFFSET_W:0] left_lim;    // TEXT_COLUMNS - text_length
   logic [LEN_W:0]           len_sum;
   logic [LEN_W-1:0]         len_sat;
   logic [TIME_W-1:0]        blink_dt;
   logic                     bounce_fits;

   assign cur      = state_ff[s1_line_ff];
   assign off_ext  = (OFFSET_W+1)'(cur.offset);
   assign off_dec  = off_ext - (OFFSET_W+1)'(1);
   assign off_inc  = off_ext + (OFFSET_W+1)'(1);
   assign left_lim = COLS_S - $signed({3'b000, cur.text_length});
   assign len_sum  = {1'b0, s1_len_ff} + (LEN_W+1)'(TEXT_COLUMNS);
   assign len_sat  = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
   assign blink_dt = s1_now_ff - cur.blink_start_time;
   // bounce only when the text is longer than the display
   assign bounce_fits = ({1'b0, s1_len_ff} <= (LEN_W+1)'(TEXT_COLUMNS));

   always_comb begin
      state_in = cur;
      unique case (s1_op_ff)
         OP_LOAD: begin
            state_in.effect_running = 1'b0;
            state_in.blinking       = 1'b0;
            state_in.blink_phase    = 1'b1;
            state_in.text_length    = s1_len_ff;
            state_in.offset         = '0;
            state_in.bounce_phase   = '0;
            state_in.effect_mode    = FX_OFF;
            unique case (effect_type'(s1_effect_ff))
               FX_BOUNCE: begin
                  if (!bounce_fits) begin
                     state_in.effect_mode    = FX_BOUNCE;
                     state_in.tick_period    = PERIOD_W'(BOUNCE_PERIOD);
                     state_in.effect_running = 1'b1;
                  end
               end
               FX_LEFT: begin
                  state_in.effect_mode    = FX_LEFT;
                  state_in.text_length    = len_sat;
                  state_in.tick_period    = PERIOD_W'(SCROLL_PERIOD);
                  state_in.effect_running = 1'b1;
               end
               FX_RIGHT: begin
                  state_in.effect_mode    = FX_RIGHT;
                  state_in.offset         = OFFSET_W'(-$signed({2'b00, s1_len_ff}));
                  state_in.text_length    = len_sat;
                  state_in.tick_period    = PERIOD_W'(SCROLL_PERIOD);
                  state_in.effect_running = 1'b1;
               end
               default: begin
                  // effect off: tick period kept
               end
            endcase
         end
         OP_EFFECT_TICK: begin
            if (cur.effect_running) begin
               unique case (cur.effect_mode)
                  FX_LEFT: begin
                     state_in.offset = off_dec[OFFSET_W-1:0];
                     if (off_dec < left_lim) state_in.effect_running = 1'b0;
                  end
                  FX_RIGHT: begin
                     state_in.offset = off_inc[OFFSET_W-1:0];
                     if (off_inc > 0) state_in.effect_running = 1'b0;
                  end
                  FX_BOUNCE: begin
                     // phases 1-3 and 5-7 are pauses; 3-bit phase wraps 7 -> 0
                     if (!cur.bounce_phase[PHASE_W-1]) begin
                        if (cur.bounce_phase == BOUNCE_SWEEP_LEFT && off_ext > left_lim)
                           state_in.offset = off_dec[OFFSET_W-1:0];
                        else
                           state_in.bounce_phase = cur.bounce_phase + 3'd1;
                     end else begin
                        if (cur.bounce_phase == BOUNCE_SWEEP_RIGHT && off_ext < 0)
                           state_in.offset = off_inc[OFFSET_W-1:0];
                        else
                           state_in.bounce_phase = cur.bounce_phase + 3'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_BLINK_START: begin
            state_in.blink_tick_period = s1_interval_ff;
            state_in.blinking          = 1'b1;
            state_in.blink_phase       = 1'b0;
            state_in.blink_duration    = s1_limit_ff;
            state_in.blink_start_time  = s1_now_ff;
         end
         OP_BLINK_STOP: begin
            state_in.blinking    = 1'b0;
            state_in.blink_phase = 1'b1;
         end
         OP_BLINK_TICK: begin
            if (cur.blinking) begin
               state_in.blink_phase = !cur.blink_phase;
               // a nonzero limit ends the blink on the normal text
               if (cur.blink_duration != '0 &&
                   blink_dt > {{(TIME_W-PERIOD_W){1'b0}}, cur.blink_duration}) begin
                  state_in.blink_phase = 1'b1;
                  state_in.blinking    = 1'b0;
               end
            end
         end
         default: begin
            // unused op codes only report the line
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) state_ff[i] <= LINE_RESET;
      end else if (advance) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            if (i[0] == s1_line_ff) state_ff[i] <= state_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result register: reports the addressed line after its update
   // ---------------------------------------------------------------
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_line_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_in;

   assign rsp_data_in = {
      4'b0000,
      state_in.blink_tick_period,
      state_in.blinking,
      state_in.tick_period,
      state_in.effect_running,
      state_in.blinking && state_in.blink_phase,
      state_in.offset[OFFSET_W-2:0]
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_line_ff <= s1_line_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_line_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   localparam logic signed [OFFSET_W-1:0] OFF_MIN = -OFFSET_W'(255);
   localparam logic signed [OFFSET_W-1:0] OFF_MAX = OFFSET_W'(1);

   a_offset_range0: assert property (@(posedge clock) disable iff (reset)
      state_ff[0].offset >= OFF_MIN && state_ff[0].offset <= OFF_MAX)
      else $error("line 0 offset out of range");

   a_offset_range1: assert property (@(posedge clock) disable iff (reset)
      state_ff[1].offset >= OFF_MIN && state_ff[1].offset <= OFF_MAX)
      else $error("line 1 offset out of range");

   a_no_run_when_off: assert property (@(posedge clock) disable iff (reset)
      !(state_ff[0].effect_running && state_ff[0].effect_mode == FX_OFF) &&
      !(state_ff[1].effect_running && state_ff[1].effect_mode == FX_OFF))
      else $error("effect running with mode off");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff[0]) && $stable(state_ff[1]))
      else $error("line state changed without an item");

   a_bounce_long: assert property (@(posedge clock) disable iff (reset)
      state_ff[s1_line_ff].effect_mode == FX_BOUNCE |->
      {1'b0, state_ff[s1_line_ff].text_length} > (LEN_W+1)'(TEXT_COLUMNS))
      else $error("bounce on text that fits the display");

endmodule
